### src/stretched_clock_step_scheduler_core_defines.svh
// assertion helpers shared by the scheduler modules
// every module that uses them has clk and arst_n in scope
`ifndef STRETCHED_CLOCK_STEP_SCHEDULER_CORE_DEFINES_SVH
`define STRETCHED_CLOCK_STEP_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define SCS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler same-cycle check failed");

// next-cycle implication
`define SCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler next-cycle check failed");

`endif

### src/scs_pkg.sv
package scs_pkg;

	localparam int MAX_STEP_LIMIT = 64;
	localparam int STEP_W = 7;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [32:0] TERM_SAT = 33'h1_0000_0000;
	localparam logic [16:0] ALPHA_ONE = 17'h1_0000;

	// datapath operation codes, one in each microcode word
	typedef logic [4:0] op_t;
	localparam op_t OP_NOP       = 5'd0;
	localparam op_t OP_ELAPSED   = 5'd1;
	localparam op_t OP_MUL_LO    = 5'd2;
	localparam op_t OP_MUL_HI    = 5'd3;
	localparam op_t OP_SCALE     = 5'd4;
	localparam op_t OP_SLEW      = 5'd5;
	localparam op_t OP_ERR_SUM   = 5'd6;
	localparam op_t OP_ERR_DIFF  = 5'd7;
	localparam op_t OP_MAG       = 5'd8;
	localparam op_t OP_GAIN_HI   = 5'd9;
	localparam op_t OP_GAIN_LO   = 5'd10;
	localparam op_t OP_TERM      = 5'd11;
	localparam op_t OP_TARGET    = 5'd12;
	localparam op_t OP_CLAMP     = 5'd13;
	localparam op_t OP_DELTA     = 5'd14;
	localparam op_t OP_ALPHA     = 5'd15;
	localparam op_t OP_SMOOTH    = 5'd16;
	localparam op_t OP_LOOP_INIT = 5'd17;
	localparam op_t OP_LOOP_STEP = 5'd18;
	localparam op_t OP_TALLY     = 5'd19;
	localparam op_t OP_OUT       = 5'd20;
	localparam op_t OP_START     = 5'd21;

	typedef struct packed {
		op_t  op;
		logic idle;
	} ctrl_t;

	typedef struct packed {
		logic cmd_start;
		logic below_band;
		logic step_more;
	} dp_status_t;

	typedef struct packed {
		logic       item;
		logic       out_busy;
		dp_status_t dp;
	} seq_status_t;

	typedef struct packed {
		logic [32:0]       step_period;
		logic [STEP_W-1:0] max_steps;
		logic [15:0]       loop_gain;
		logic [32:0]       dead_band;
		logic [30:0]       stretch_upper;
		logic [30:0]       stretch_lower;
		logic [16:0]       smooth_alpha;
	} cfg_t;

endpackage

### src/scs_seq.sv
`include "stretched_clock_step_scheduler_core_defines.svh"

module scs_seq
	import scs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output ctrl_t       ctrl
);

	localparam int ADDR_W = 5;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [2:0] cond_t;

	localparam cond_t C_NEVER      = 3'd0;
	localparam cond_t C_ALWAYS     = 3'd1;
	localparam cond_t C_NO_ITEM    = 3'd2;
	localparam cond_t C_CMD_START  = 3'd3;
	localparam cond_t C_BELOW_BAND = 3'd4;
	localparam cond_t C_STEP_MORE  = 3'd5;
	localparam cond_t C_OUT_BUSY   = 3'd6;

	localparam addr_t A_WAIT      = 5'd0;
	localparam addr_t A_ELAPSED   = 5'd1;
	localparam addr_t A_MUL_LO    = 5'd2;
	localparam addr_t A_MUL_HI    = 5'd3;
	localparam addr_t A_SCALE     = 5'd4;
	localparam addr_t A_SLEW      = 5'd5;
	localparam addr_t A_ERR_SUM   = 5'd6;
	localparam addr_t A_ERR_DIFF  = 5'd7;
	localparam addr_t A_MAG       = 5'd8;
	localparam addr_t A_GAIN_HI   = 5'd9;
	localparam addr_t A_GAIN_LO   = 5'd10;
	localparam addr_t A_TERM      = 5'd11;
	localparam addr_t A_TARGET    = 5'd12;
	localparam addr_t A_CLAMP     = 5'd13;
	localparam addr_t A_DELTA     = 5'd14;
	localparam addr_t A_ALPHA     = 5'd15;
	localparam addr_t A_SMOOTH    = 5'd16;
	localparam addr_t A_LOOP_INIT = 5'd17;
	localparam addr_t A_LOOP      = 5'd18;
	localparam addr_t A_TALLY     = 5'd19;
	localparam addr_t A_FINISH    = 5'd20;
	localparam addr_t A_RETURN    = 5'd21;
	localparam addr_t A_START     = 5'd22;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		addr_t target;
	} uword_t;

	// control store
	function automatic uword_t ucode_word(input addr_t addr);
		uword_t w;
		case (addr)
			A_WAIT:      w = uword_t'({OP_NOP,       C_NO_ITEM,    A_WAIT});
			A_ELAPSED:   w = uword_t'({OP_ELAPSED,   C_CMD_START,  A_START});
			A_MUL_LO:    w = uword_t'({OP_MUL_LO,    C_NEVER,      A_WAIT});
			A_MUL_HI:    w = uword_t'({OP_MUL_HI,    C_NEVER,      A_WAIT});
			A_SCALE:     w = uword_t'({OP_SCALE,     C_NEVER,      A_WAIT});
			A_SLEW:      w = uword_t'({OP_SLEW,      C_NEVER,      A_WAIT});
			A_ERR_SUM:   w = uword_t'({OP_ERR_SUM,   C_NEVER,      A_WAIT});
			A_ERR_DIFF:  w = uword_t'({OP_ERR_DIFF,  C_NEVER,      A_WAIT});
			A_MAG:       w = uword_t'({OP_MAG,       C_NEVER,      A_WAIT});
			A_GAIN_HI:   w = uword_t'({OP_GAIN_HI,   C_NEVER,      A_WAIT});
			A_GAIN_LO:   w = uword_t'({OP_GAIN_LO,   C_NEVER,      A_WAIT});
			A_TERM:      w = uword_t'({OP_TERM,      C_NEVER,      A_WAIT});
			A_TARGET:    w = uword_t'({OP_TARGET,    C_NEVER,      A_WAIT});
			A_CLAMP:     w = uword_t'({OP_CLAMP,     C_NEVER,      A_WAIT});
			A_DELTA:     w = uword_t'({OP_DELTA,     C_BELOW_BAND, A_LOOP_INIT});
			A_ALPHA:     w = uword_t'({OP_ALPHA,     C_NEVER,      A_WAIT});
			A_SMOOTH:    w = uword_t'({OP_SMOOTH,    C_NEVER,      A_WAIT});
			A_LOOP_INIT: w = uword_t'({OP_LOOP_INIT, C_NEVER,      A_WAIT});
			A_LOOP:      w = uword_t'({OP_LOOP_STEP, C_STEP_MORE,  A_LOOP});
			A_TALLY:     w = uword_t'({OP_TALLY,     C_NEVER,      A_WAIT});
			A_FINISH:    w = uword_t'({OP_OUT,       C_OUT_BUSY,   A_FINISH});
			A_RETURN:    w = uword_t'({OP_NOP,       C_ALWAYS,     A_WAIT});
			A_START:     w = uword_t'({OP_START,     C_ALWAYS,     A_FINISH});
			default:     w = uword_t'({OP_NOP,       C_ALWAYS,     A_WAIT});
		endcase
		return w;
	endfunction

	addr_t  upc_q;
	uword_t word;
	logic   take;

	assign word = ucode_word(upc_q);

	always_comb begin
		unique case (word.cond)
			C_NEVER:      take = 1'b0;
			C_ALWAYS:     take = 1'b1;
			C_NO_ITEM:    take = !status.item;
			C_CMD_START:  take = status.dp.cmd_start;
			C_BELOW_BAND: take = status.dp.below_band;
			C_STEP_MORE:  take = status.dp.step_more;
			C_OUT_BUSY:   take = status.out_busy;
			default:      take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= A_WAIT;
		end else if (take) begin
			upc_q <= word.target;
		end else begin
			upc_q <= upc_q + addr_t'(1);
		end
	end

	assign ctrl.op   = word.op;
	assign ctrl.idle = (upc_q == A_WAIT);

	`SCS_ASSERT_NOW(a_item_at_wait, status.item, upc_q == A_WAIT)
	`SCS_ASSERT_NEXT(a_loop_holds, (upc_q == A_LOOP) && status.dp.step_more, upc_q == A_LOOP)
	`SCS_ASSERT_NEXT(a_finish_leaves, (upc_q == A_FINISH) && !status.out_busy,
		upc_q == A_RETURN)

endmodule

### src/scs_dp.sv
module scs_dp
	import scs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	input  cfg_t              cfg,
	input  logic              in_fire,
	input  logic              cmd,
	input  logic [63:0]       now_time,
	input  logic [63:0]       ref_offset,
	output dp_status_t        status,
	output logic [STEP_W-1:0] granted,
	output logic [31:0]       total,
	output logic [30:0]       stretch
);

	// latched transaction
	logic        cmd_q;
	logic [63:0] now_q;
	logic [63:0] offset_q;

	// architectural state
	logic [63:0] slewed_q;
	logic [63:0] prev_q;
	logic [63:0] acc_q;
	logic [30:0] sf_q;
	logic [31:0] total_q;

	// scratch registers
	logic [63:0]       elapsed_q;
	logic [62:0]       prod_q;
	logic [63:0]       scaled_q;
	logic [63:0]       err_q;
	logic [63:0]       mag_q;
	logic              neg_q;
	logic [48:0]       term_q;
	logic [34:0]       target_q;
	logic [30:0]       clamp_q;
	logic [30:0]       dm_q;
	logic              dneg_q;
	logic [STEP_W-1:0] granted_q;
	logic [STEP_W-1:0] cap_q;

	// shared multiplier
	logic [31:0] mul_a;
	logic [30:0] mul_b;
	logic        mul_en;
	logic [62:0] mul_res;

	logic [16:0]       alpha_eff;
	logic [STEP_W-1:0] cap_eff;
	logic [63:0]       gap;
	logic              step_more;
	logic [32:0]       term_sat;
	logic [31:0]       delta;
	logic [30:0]       move;

	assign alpha_eff = (cfg.smooth_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.smooth_alpha;
	assign cap_eff   = (cfg.max_steps > STEP_W'(MAX_STEP_LIMIT)) ?
		STEP_W'(MAX_STEP_LIMIT) : cfg.max_steps;

	always_comb begin
		mul_en = 1'b1;
		unique case (ctrl.op)
			OP_MUL_LO: begin
				mul_a = elapsed_q[31:0];
				mul_b = sf_q;
			end
			OP_MUL_HI: begin
				mul_a = elapsed_q[63:32];
				mul_b = sf_q;
			end
			OP_GAIN_HI: begin
				mul_a = mag_q[49:18];
				mul_b = {15'b0, cfg.loop_gain};
			end
			OP_GAIN_LO: begin
				mul_a = {14'b0, mag_q[17:0]};
				mul_b = {15'b0, cfg.loop_gain};
			end
			OP_ALPHA: begin
				mul_a = {1'b0, dm_q};
				mul_b = {14'b0, alpha_eff};
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_res = 63'(mul_a) * 63'(mul_b);

	// steps still owed: count below cap and accumulator strictly behind
	assign gap       = slewed_q - acc_q;
	assign step_more = (granted_q < cap_q) && (gap != 64'd0) && !gap[63];

	// anything from bit 50 up times a nonzero gain already reaches the saturation
	assign term_sat = (((mag_q[63:50] != 14'd0) && (cfg.loop_gain != 16'd0)) ||
		(term_q > {16'b0, TERM_SAT})) ? TERM_SAT : term_q[32:0];

	assign delta = {1'b0, clamp_q} - {1'b0, sf_q};
	assign move  = prod_q[46:16];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q    <= cmd;
			now_q    <= now_time;
			offset_q <= ref_offset;
		end
		if (mul_en) begin
			prod_q <= mul_res;
		end
		unique case (ctrl.op)
			OP_ELAPSED:   elapsed_q <= now_q - prev_q;
			OP_MUL_HI:    scaled_q <= 64'(prod_q[62:30]);
			OP_SCALE:     scaled_q <= scaled_q + {prod_q[61:0], 2'b00};
			OP_ERR_SUM:   err_q <= now_q + offset_q;
			OP_ERR_DIFF:  err_q <= err_q - slewed_q;
			OP_MAG: begin
				neg_q <= err_q[63];
				mag_q <= err_q[63] ? (64'd0 - err_q) : err_q;
			end
			OP_GAIN_LO:   term_q <= prod_q[48:0];
			OP_TERM:      term_q <= term_q + 49'(prod_q[33:18]);
			OP_TARGET:    target_q <= neg_q ? (35'(ONE_Q30) - 35'(term_sat)) :
				(35'(ONE_Q30) + 35'(term_sat));
			OP_CLAMP: begin
				if ($signed(target_q) < $signed({4'b0, cfg.stretch_lower})) begin
					clamp_q <= cfg.stretch_lower;
				end else if ($signed(target_q) > $signed({4'b0, cfg.stretch_upper})) begin
					clamp_q <= cfg.stretch_upper;
				end else begin
					clamp_q <= target_q[30:0];
				end
			end
			OP_DELTA: begin
				dneg_q <= delta[31];
				dm_q   <= delta[31] ? 31'(32'd0 - delta) : delta[30:0];
			end
			OP_LOOP_INIT: begin
				granted_q <= '0;
				cap_q     <= cap_eff;
			end
			OP_LOOP_STEP: begin
				if (step_more) begin
					granted_q <= granted_q + STEP_W'(1);
				end
			end
			OP_START:     granted_q <= '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slewed_q <= '0;
			prev_q   <= '0;
			acc_q    <= '0;
			sf_q     <= ONE_Q30;
			total_q  <= '0;
		end else begin
			unique case (ctrl.op)
				OP_ELAPSED:   prev_q <= now_q;
				OP_SLEW:      slewed_q <= slewed_q + scaled_q;
				OP_SMOOTH:    sf_q <= dneg_q ? (sf_q - move) : (sf_q + move);
				OP_LOOP_STEP: begin
					if (step_more) begin
						acc_q <= acc_q + {31'b0, cfg.step_period};
					end
				end
				OP_TALLY:     total_q <= total_q + 32'(granted_q);
				OP_START: begin
					slewed_q <= now_q;
					prev_q   <= now_q;
					acc_q    <= now_q;
				end
				default: ;
			endcase
		end
	end

	assign status.cmd_start  = !cmd_q;
	assign status.below_band = (mag_q < {31'b0, cfg.dead_band});
	assign status.step_more  = step_more;

	assign granted = granted_q;
	assign total   = total_q;
	assign stretch = sf_q;

endmodule

### src/stretched_clock_step_scheduler_core.sv
// stretched clock step scheduler: slews a game clock toward a reference clock
// and hands out fixed simulation steps for each display frame
// input channel in_valid/in_ready carries cmd, now_time and ref_offset;
// cmd low loads every clock with now_time, cmd high runs a frame update
// output channel out_valid/out_ready returns steps_granted, steps_total and
// stretch_now, exactly one result per input transaction
// config channel cfg_valid/cfg_ready writes cfg_data into register cfg_index,
// always ready, only to be used while no transaction is in flight
// a start command runs the elapsed and start steps and then the finish step;
// a frame update runs the steps from elapsed through tally and then finish,
// skipping alpha and smooth when the error is inside the dead band; the step
// loop in the microcode grants one step per cycle; the sequencer takes one
// transaction at a time and, after the result is loaded, goes through its
// return step back to the wait step, where it accepts the next one
// a finished result sits in the output register; the next transaction is
// accepted while it waits, but the sequencer stalls on its finish step while
// the output register is still full
// reset clears the clocks, the step count and the output valid, sets the
// stretch to one and loads every config register with its default
`include "stretched_clock_step_scheduler_core_defines.svh"

module stretched_clock_step_scheduler_core
	import scs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input transaction
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [63:0]       now_time,
	input  logic [63:0]       ref_offset,
	// result transaction
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STEP_W-1:0] steps_granted,
	output logic [31:0]       steps_total,
	output logic [30:0]       stretch_now,
	// config write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [32:0]       cfg_data
);

	// register map
	localparam logic [2:0] REG_STEP_PERIOD   = 3'd0;
	localparam logic [2:0] REG_MAX_STEPS     = 3'd1;
	localparam logic [2:0] REG_LOOP_GAIN     = 3'd2;
	localparam logic [2:0] REG_DEAD_BAND     = 3'd3;
	localparam logic [2:0] REG_STRETCH_UPPER = 3'd4;
	localparam logic [2:0] REG_STRETCH_LOWER = 3'd5;
	localparam logic [2:0] REG_SMOOTH_ALPHA  = 3'd6;

	cfg_t        cfg_q;
	ctrl_t       ctrl;
	dp_status_t  dp_status;
	seq_status_t seq_status;

	logic              in_fire;
	logic              out_busy;
	logic              out_load;
	logic              out_valid_q;
	logic [STEP_W-1:0] granted_q;
	logic [31:0]       total_q;
	logic [30:0]       stretch_q;
	logic [STEP_W-1:0] dp_granted;
	logic [31:0]       dp_total;
	logic [30:0]       dp_stretch;

	// config registers, writes to the unused index are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_period   <= 33'd71582788;
			cfg_q.max_steps     <= STEP_W'(8);
			cfg_q.loop_gain     <= 16'd655;
			cfg_q.dead_band     <= 33'd4294967;
			cfg_q.stretch_upper <= 31'd1127428915;
			cfg_q.stretch_lower <= 31'd1022611260;
			cfg_q.smooth_alpha  <= 17'd6554;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP_PERIOD:   cfg_q.step_period   <= cfg_data;
				REG_MAX_STEPS:     cfg_q.max_steps     <= cfg_data[STEP_W-1:0];
				REG_LOOP_GAIN:     cfg_q.loop_gain     <= cfg_data[15:0];
				REG_DEAD_BAND:     cfg_q.dead_band     <= cfg_data;
				REG_STRETCH_UPPER: cfg_q.stretch_upper <= cfg_data[30:0];
				REG_STRETCH_LOWER: cfg_q.stretch_lower <= cfg_data[30:0];
				REG_SMOOTH_ALPHA:  cfg_q.smooth_alpha  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// input side: the sequencer takes a transaction only on its wait step
	assign in_ready = ctrl.idle;
	assign in_fire  = in_valid && in_ready;

	// output side: the finish step loads the result once the register frees up
	assign out_busy = out_valid_q && !out_ready;
	assign out_load = (ctrl.op == OP_OUT) && !out_busy;

	assign seq_status.item     = in_fire;
	assign seq_status.out_busy = out_busy;
	assign seq_status.dp       = dp_status;

	scs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (seq_status),
		.ctrl   (ctrl)
	);

	scs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg        (cfg_q),
		.in_fire    (in_fire),
		.cmd        (cmd),
		.now_time   (now_time),
		.ref_offset (ref_offset),
		.status     (dp_status),
		.granted    (dp_granted),
		.total      (dp_total),
		.stretch    (dp_stretch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			granted_q <= dp_granted;
			total_q   <= dp_total;
			stretch_q <= dp_stretch;
		end
	end

	assign out_valid     = out_valid_q;
	assign steps_granted = granted_q;
	assign steps_total   = total_q;
	assign stretch_now   = stretch_q;

	`SCS_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
	`SCS_ASSERT_NOW(a_granted_capped, out_valid, steps_granted <= STEP_W'(MAX_STEP_LIMIT))
	`SCS_ASSERT_NOW(a_start_grants_none, out_load && dp_status.cmd_start,
		dp_granted == '0)

endmodule
